// ===== rtl/core/rrg_pkg.sv =====
// shared types and constants for the refraction ray generator
// no dependencies; imported by every module of the block
package rrg_pkg;

  // one incoming ray: direction and normal in Q2.14, hit point in Q16.16
  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  // one refracted ray: origin in Q16.16, direction in Q2.14
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    logic               internal_reflection;
  } out_item_t;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REFR_IDX   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_IDX = 1'b1;

  localparam int RI_W  = 15;
  localparam int OFF_W = 16;
  localparam int ER_W  = 13;
  localparam logic [RI_W-1:0]  RI_RESET  = 15'd6144;
  localparam logic [RI_W-1:0]  RI_MIN    = 15'd4096;
  localparam logic [OFF_W-1:0] OFF_RESET = 16'd7;

  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

  // pipelined square root
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_ARG_W  = 64;
  localparam int SQRT_ROOT_W = 32;

  // pipelined normalizing divider
  localparam int DIV_STEPS = 15;
  localparam int DIV_NUM_W = 45;
  localparam int DIV_DEN_W = 31;

  // iterative reciprocal of the index
  localparam int RECIP_STEPS = 13;
  localparam int RECIP_CNT_W = 4;
  localparam int RECIP_NUM_W = 25;
  localparam logic [RECIP_NUM_W-1:0] RECIP_NUM = 25'h100_0000;

endpackage

// ===== rtl/core/rrg_sqrt_pipe.sv =====
// fully pipelined integer floor square root, one result bit per stage
// depends on rrg_pkg
module rrg_sqrt_pipe (
  input  logic                            clk,
  input  logic                            en,
  input  logic [rrg_pkg::SQRT_ARG_W-1:0]  arg,
  output logic [rrg_pkg::SQRT_ROOT_W-1:0] root
);
  import rrg_pkg::*;

  logic [SQRT_ARG_W-1:0] rem_r [SQRT_STEPS];
  logic [SQRT_ARG_W-1:0] acc_r [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam int SH = SQRT_ARG_W - 2 - 2 * k;
      logic [SQRT_ARG_W-1:0] rem_in;
      logic [SQRT_ARG_W-1:0] acc_in;
      logic [SQRT_ARG_W-1:0] bit_val;
      logic [SQRT_ARG_W-1:0] trial;

      if (k == 0) begin : g_first
        assign rem_in = arg;
        assign acc_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign acc_in = acc_r[k-1];
      end

      assign bit_val = SQRT_ARG_W'(1) << SH;
      assign trial   = acc_in + bit_val;

      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in >= trial) begin
            rem_r[k] <= rem_in - trial;
            acc_r[k] <= (acc_in >> 1) + bit_val;
          end else begin
            rem_r[k] <= rem_in;
            acc_r[k] <= acc_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign root = acc_r[SQRT_STEPS-1][SQRT_ROOT_W-1:0];

endmodule

// ===== rtl/core/rrg_div_lane.sv =====
// pipelined restoring divider for one direction component, one quotient bit per stage
// depends on rrg_pkg; quotient must fit in DIV_STEPS bits
module rrg_div_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rrg_pkg::DIV_NUM_W-1:0] num,
  input  logic [rrg_pkg::DIV_DEN_W-1:0] den,
  output logic [rrg_pkg::DIV_STEPS-1:0] quot
);
  import rrg_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int SH = DIV_STEPS - 1 - k;
      logic [DIV_NUM_W-1:0] rem_in;
      logic [DIV_DEN_W-1:0] den_in;
      logic [DIV_STEPS-1:0] q_in;
      logic [DIV_NUM_W:0]   trial;
      logic                 take;

      if (k == 0) begin : g_first
        assign rem_in = num;
        assign den_in = den;
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign den_in = den_r[k-1];
        assign q_in   = q_r[k-1];
      end

      assign trial = (DIV_NUM_W + 1)'(den_in) << SH;
      assign take  = {1'b0, rem_in} >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_in - trial[DIV_NUM_W-1:0]) : rem_in;
          den_r[k] <= den_in;
          q_r[k]   <= {q_in[DIV_STEPS-2:0], take};
        end
      end
    end
  endgenerate

  assign quot = q_r[DIV_STEPS-1];

endmodule

// ===== rtl/core/rrg_recip_div.sv =====
// iterative divider for the rounded reciprocal of the refraction index (Q12)
// depends on rrg_pkg; reruns after reset and after every index write
module rrg_recip_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rrg_pkg::RI_W-1:0] divisor,
  output logic                     busy,
  output logic [rrg_pkg::ER_W-1:0] quot
);
  import rrg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [RECIP_NUM_W-1:0] rem_r, rem_nxt;
  logic [RI_W-1:0]        den_r, den_nxt;
  logic [RECIP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ER_W-1:0]        quot_r, quot_nxt;
  logic [RECIP_NUM_W+2:0] trial;
  logic                   take;

  assign trial = (RECIP_NUM_W + 3)'(den_r) << cnt_r;
  assign take  = {3'b0, rem_r} >= trial;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    quot_nxt  = quot_r;
    case (state_r)
      ST_LOAD: begin
        rem_nxt   = RECIP_NUM + RECIP_NUM_W'(divisor >> 1);
        den_nxt   = divisor;
        cnt_nxt   = RECIP_CNT_W'(RECIP_STEPS - 1);
        quot_nxt  = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (take) begin
          rem_nxt = rem_r - trial[RECIP_NUM_W-1:0];
        end
        quot_nxt = {quot_r[ER_W-2:0], take};
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = state_r != ST_IDLE;
  assign quot = quot_r;

endmodule

// ===== rtl/core/refraction_ray_generator_top.sv =====
// throughput: one ray per cycle, set by the fully pipelined square root and divider stages,
// as long as neither a held result nor a running reciprocal stalls the input
// the pipeline moves while the result register is free or not stalled, or the last stage holds a bubble
// reset (synchronous, active low) clears valids and loads index 1.5 and offset 7;
// the reciprocal of the index is then computed, with in_stall high meanwhile,
// and it is computed again, with in_stall high, after every write of the index register
module refraction_ray_generator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rrg_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rrg_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rrg_pkg::*;

  // stage map: s1..s6, square root a, s7..s11, square root b, s12, divider, s13, s14
  localparam int PIPE_LEN = 6 + SQRT_STEPS + 5 + SQRT_STEPS + 1 + DIV_STEPS + 2;

  // direction, normal (negated for leaving rays) and point carried alongside the front stages
  typedef struct packed {
    logic [2:0][15:0] d;
    logic [2:0][16:0] nn;
    logic [2:0][31:0] p;
  } geo_t;

  // sideband beside the first square root
  typedef struct packed {
    logic [RI_W-1:0] er;
    logic [43:0]     ercos;
    geo_t            geo;
    logic            tir;
  } side_a_t;

  // sideband beside the second square root
  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic [2:0][31:0] p;
    logic             tir;
  } side_b_t;

  // sideband beside the dividers
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] p;
    logic             tir;
    logic             zero;
  } side_c_t;

  // ---------------------------------------------------------------- config
  logic [RI_W-1:0]  ri_r;
  logic [OFF_W-1:0] off_r;
  logic [RI_W-1:0]  ri_clamp;
  logic [ER_W-1:0]  er_ent;
  logic             cfg_wr;
  logic             recip_start;
  logic             recip_busy;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign recip_start = cfg_wr && (cfg_index == CFG_REFR_IDX);
  // index below range acts as 1.0
  assign ri_clamp    = (ri_r < RI_MIN) ? RI_MIN : ri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ri_r  <= RI_RESET;
      off_r <= OFF_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_REFR_IDX:   ri_r  <= cfg_data[RI_W-1:0];
        CFG_OFFSET_IDX: off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // 1/ior in Q12, rounded half up, used for rays entering the medium
  rrg_recip_div u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recip_start),
    .divisor (ri_clamp),
    .busy    (recip_busy),
    .quot    (er_ent)
  );

  // --------------------------------------------------------- flow control
  logic                out_valid_r;
  out_item_t           out_data_r;
  logic [PIPE_LEN-1:0] vld_r;
  logic                en;
  logic                accept;

  // the whole pipeline shifts unless a held result blocks a valid last stage
  assign en       = !out_valid_r || !out_stall || !vld_r[PIPE_LEN-1];
  assign in_stall = !en || recip_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], accept};
    end
  end

  // ---------------------------------------------------- s1: input capture
  in_item_t in_1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      in_1_r <= in_data;
    end
  end

  // ---------------------------------------------------- s2: dot(dir, normal)
  logic signed [31:0] dn_prod [3];
  logic [33:0]        c0_nxt;
  logic [33:0]        c0_2_r;
  in_item_t           in_2_r;

  always_comb begin
    dn_prod[0] = in_1_r.dir_x * in_1_r.normal_x;
    dn_prod[1] = in_1_r.dir_y * in_1_r.normal_y;
    dn_prod[2] = in_1_r.dir_z * in_1_r.normal_z;
    c0_nxt = {{2{dn_prod[0][31]}}, dn_prod[0]} + {{2{dn_prod[1][31]}}, dn_prod[1]}
           + {{2{dn_prod[2][31]}}, dn_prod[2]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_2_r <= c0_nxt;
      in_2_r <= in_1_r;
    end
  end

  // ---------------------------------------------------- s3: side select
  logic        enter;
  logic [33:0] c0_abs;
  logic [28:0] cos1_nxt;
  logic [RI_W-1:0] er_nxt;
  logic [16:0] n_ext [3];
  geo_t        geo_nxt;
  logic [28:0] cos1_3_r;
  logic [RI_W-1:0] er_3_r;
  geo_t        geo_3_r;

  // a zero dot product counts as leaving
  always_comb begin
    enter    = c0_2_r[33];
    c0_abs   = enter ? (~c0_2_r + 34'd1) : c0_2_r;
    cos1_nxt = (c0_abs > {5'b0, ONE_Q28}) ? ONE_Q28 : c0_abs[28:0];
    er_nxt   = enter ? {{(RI_W-ER_W){1'b0}}, er_ent} : ri_clamp;
    n_ext[0] = {in_2_r.normal_x[15], in_2_r.normal_x};
    n_ext[1] = {in_2_r.normal_y[15], in_2_r.normal_y};
    n_ext[2] = {in_2_r.normal_z[15], in_2_r.normal_z};
    geo_nxt.d[0] = in_2_r.dir_x;
    geo_nxt.d[1] = in_2_r.dir_y;
    geo_nxt.d[2] = in_2_r.dir_z;
    geo_nxt.p[0] = in_2_r.point_x;
    geo_nxt.p[1] = in_2_r.point_y;
    geo_nxt.p[2] = in_2_r.point_z;
    for (int i = 0; i < 3; i++) begin
      geo_nxt.nn[i] = enter ? n_ext[i] : (~n_ext[i] + 17'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos1_3_r <= cos1_nxt;
      er_3_r   <= er_nxt;
      geo_3_r  <= geo_nxt;
    end
  end

  // ---------------------------------------------------- s4: products of cos1 and eta
  logic [57:0] cos1sq_4_r;
  logic [29:0] ersq_4_r;
  logic [43:0] ercos_4_r;
  logic [RI_W-1:0] er_4_r;
  geo_t        geo_4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cos1sq_4_r <= cos1_3_r * cos1_3_r;
      ersq_4_r   <= er_3_r * er_3_r;
      ercos_4_r  <= er_3_r * cos1_3_r;
      er_4_r     <= er_3_r;
      geo_4_r    <= geo_3_r;
    end
  end

  // ---------------------------------------------------- s5: eta^2 * sin^2
  logic [56:0] sin_diff;
  logic [28:0] s1;
  logic [58:0] prod_5_r;
  logic [43:0] ercos_5_r;
  logic [RI_W-1:0] er_5_r;
  geo_t        geo_5_r;

  assign sin_diff = {1'b1, 56'b0} - cos1sq_4_r[56:0];
  assign s1       = sin_diff[56:28];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_5_r  <= ersq_4_r * s1;
      ercos_5_r <= ercos_4_r;
      er_5_r    <= er_4_r;
      geo_5_r   <= geo_4_r;
    end
  end

  // ---------------------------------------------------- s6: tir test, cos2 argument
  logic [34:0] s2;
  logic        tir_nxt;
  logic [28:0] cos_diff;
  logic [SQRT_ARG_W-1:0] arg_a_nxt;
  logic [SQRT_ARG_W-1:0] arg_a_r;
  side_a_t     side_a_nxt;
  side_a_t     side_6_r;

  always_comb begin
    s2        = prod_5_r[58:24];
    tir_nxt   = s2 > {6'b0, ONE_Q28};
    cos_diff  = ONE_Q28 - s2[28:0];
    arg_a_nxt = tir_nxt ? '0 : {7'b0, cos_diff, 28'b0};
    side_a_nxt.er    = er_5_r;
    side_a_nxt.ercos = ercos_5_r;
    side_a_nxt.geo   = geo_5_r;
    side_a_nxt.tir   = tir_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_a_r  <= arg_a_nxt;
      side_6_r <= side_a_nxt;
    end
  end

  // ---------------------------------------------------- square root a: cos2
  logic [SQRT_ROOT_W-1:0] root_a;
  side_a_t                sa_q_r [SQRT_STEPS];

  rrg_sqrt_pipe u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .arg  (arg_a_r),
    .root (root_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sa_q_r[0] <= side_6_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sa_q_r[k] <= sa_q_r[k-1];
      end
    end
  end

  // ---------------------------------------------------- s7: g and eta*d
  side_a_t            sa_out;
  logic [28:0]        cos2;
  logic signed [45:0] g_nxt;
  logic signed [31:0] erd_nxt [3];
  logic signed [45:0] g_7_r;
  logic signed [31:0] erd_7_r [3];
  logic signed [16:0] nn_7_r [3];
  logic [2:0][31:0]   p_7_r;
  logic               tir_7_r;

  always_comb begin
    sa_out = sa_q_r[SQRT_STEPS-1];
    cos2   = root_a[28:0];
    g_nxt  = $signed({2'b0, sa_out.ercos}) - $signed({5'b0, cos2, 12'b0});
    for (int i = 0; i < 3; i++) begin
      erd_nxt[i] = $signed({1'b0, sa_out.er}) * $signed(sa_out.geo.d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_7_r   <= g_nxt;
      p_7_r   <= sa_out.geo.p;
      tir_7_r <= sa_out.tir;
      for (int i = 0; i < 3; i++) begin
        erd_7_r[i] <= erd_nxt[i];
        nn_7_r[i]  <= $signed(sa_out.geo.nn[i]);
      end
    end
  end

  // ---------------------------------------------------- s8: g * normal
  logic signed [62:0] gn_8_r [3];
  logic signed [31:0] erd_8_r [3];
  logic [2:0][31:0]   p_8_r;
  logic               tir_8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_8_r   <= p_7_r;
      tir_8_r <= tir_7_r;
      for (int i = 0; i < 3; i++) begin
        gn_8_r[i]  <= g_7_r * nn_7_r[i];
        erd_8_r[i] <= erd_7_r[i];
      end
    end
  end

  // ---------------------------------------------------- s9: t and u = t >>> 30
  logic signed [62:0] t_sum [3];
  logic signed [30:0] u_9_r [3];
  logic [2:0][31:0]   p_9_r;
  logic               tir_9_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_sum[i] = $signed({{3{erd_8_r[i][31]}}, erd_8_r[i], 28'b0}) + gn_8_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_9_r   <= p_8_r;
      tir_9_r <= tir_8_r;
      for (int i = 0; i < 3; i++) begin
        u_9_r[i] <= t_sum[i][60:30];
      end
    end
  end

  // ---------------------------------------------------- s10: squares and magnitudes
  logic [30:0]      u_abs [3];
  logic [61:0]      usq_10_r [3];
  logic [2:0][29:0] mag_10_r;
  logic [2:0]       neg_10_r;
  logic [2:0][31:0] p_10_r;
  logic             tir_10_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_abs[i] = u_9_r[i][30] ? (~u_9_r[i] + 31'd1) : u_9_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_10_r   <= p_9_r;
      tir_10_r <= tir_9_r;
      for (int i = 0; i < 3; i++) begin
        usq_10_r[i] <= u_9_r[i] * u_9_r[i];
        mag_10_r[i] <= u_abs[i][29:0];
        neg_10_r[i] <= u_9_r[i][30];
      end
    end
  end

  // ---------------------------------------------------- s11: squared length
  logic [SQRT_ARG_W-1:0] arg_b_r;
  side_b_t               side_11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      arg_b_r <= {2'b0, usq_10_r[0]} + {2'b0, usq_10_r[1]} + {2'b0, usq_10_r[2]};
      side_11_r.mag <= mag_10_r;
      side_11_r.neg <= neg_10_r;
      side_11_r.p   <= p_10_r;
      side_11_r.tir <= tir_10_r;
    end
  end

  // ---------------------------------------------------- square root b: length
  logic [SQRT_ROOT_W-1:0] root_b;
  side_b_t                sb_q_r [SQRT_STEPS];

  rrg_sqrt_pipe u_sqrt_b (
    .clk  (clk),
    .en   (en),
    .arg  (arg_b_r),
    .root (root_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb_q_r[0] <= side_11_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sb_q_r[k] <= sb_q_r[k-1];
      end
    end
  end

  // ---------------------------------------------------- s12: rounded numerators
  side_b_t              sb_out;
  logic [DIV_DEN_W-1:0] len;
  logic [DIV_NUM_W-1:0] num_12_r [3];
  logic [DIV_DEN_W-1:0] den_12_r;
  side_c_t              side_12_r;

  assign sb_out = sb_q_r[SQRT_STEPS-1];
  assign len    = root_b[DIV_DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      den_12_r       <= len;
      side_12_r.neg  <= sb_out.neg;
      side_12_r.p    <= sb_out.p;
      side_12_r.tir  <= sb_out.tir;
      side_12_r.zero <= len == '0;
      for (int i = 0; i < 3; i++) begin
        num_12_r[i] <= {1'b0, sb_out.mag[i], 14'b0} + {15'b0, len[DIV_DEN_W-1:1]};
      end
    end
  end

  // ---------------------------------------------------- dividers: normalize
  logic [DIV_STEPS-1:0] lane_q [3];
  side_c_t              sc_q_r [DIV_STEPS];

  genvar l;
  generate
    for (l = 0; l < 3; l++) begin : g_lane
      rrg_div_lane u_div (
        .clk  (clk),
        .en   (en),
        .num  (num_12_r[l]),
        .den  (den_12_r),
        .quot (lane_q[l])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sc_q_r[0] <= side_12_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sc_q_r[k] <= sc_q_r[k-1];
      end
    end
  end

  // ---------------------------------------------------- s13: signed direction
  side_c_t            sc_out;
  logic signed [15:0] od_nxt [3];
  logic signed [15:0] od_13_r [3];
  logic [2:0][31:0]   p_13_r;
  logic               tir_13_r;

  // total internal reflection and a zero-length result both give a zero direction
  always_comb begin
    sc_out = sc_q_r[DIV_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      if (sc_out.tir || sc_out.zero) begin
        od_nxt[i] = '0;
      end else if (sc_out.neg[i]) begin
        od_nxt[i] = -$signed({1'b0, lane_q[i]});
      end else begin
        od_nxt[i] = $signed({1'b0, lane_q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_13_r   <= sc_out.p;
      tir_13_r <= sc_out.tir;
      for (int i = 0; i < 3; i++) begin
        od_13_r[i] <= od_nxt[i];
      end
    end
  end

  // ---------------------------------------------------- s14: offset step
  logic signed [32:0] stp_14_r [3];
  logic signed [15:0] od_14_r [3];
  logic [2:0][31:0]   p_14_r;
  logic               tir_14_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_14_r   <= p_13_r;
      tir_14_r <= tir_13_r;
      for (int i = 0; i < 3; i++) begin
        stp_14_r[i] <= od_13_r[i] * $signed({1'b0, off_r});
        od_14_r[i]  <= od_13_r[i];
      end
    end
  end

  // ---------------------------------------------------- result register
  logic [33:0]        stp_rnd [3];
  logic [19:0]        step [3];
  logic [32:0]        org_sum [3];
  logic [31:0]        org_sat [3];
  out_item_t          out_nxt;

  // origin = point + round(dir * offset), saturated to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      stp_rnd[i] = {stp_14_r[i][32], stp_14_r[i]} + 34'd8192;
      step[i]    = stp_rnd[i][33:14];
      org_sum[i] = {p_14_r[i][31], p_14_r[i]} + {{13{step[i][19]}}, step[i]};
      case (org_sum[i][32:31])
        2'b01:   org_sat[i] = 32'h7FFF_FFFF;
        2'b10:   org_sat[i] = 32'h8000_0000;
        default: org_sat[i] = org_sum[i][31:0];
      endcase
    end
    out_nxt.origin_x            = org_sat[0];
    out_nxt.origin_y            = org_sat[1];
    out_nxt.origin_z            = org_sat[2];
    out_nxt.out_dir_x           = od_14_r[0];
    out_nxt.out_dir_y           = od_14_r[1];
    out_nxt.out_dir_z           = od_14_r[2];
    out_nxt.internal_reflection = tir_14_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[PIPE_LEN-1]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[PIPE_LEN-1]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------- checks
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(en && vld_r[PIPE_LEN-1]))
    else $error("result appeared without an item leaving the pipeline");

  a_tir_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.internal_reflection |->
      out_data_r.out_dir_x == '0 && out_data_r.out_dir_y == '0 &&
      out_data_r.out_dir_z == '0)
    else $error("internal reflection with a nonzero direction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_data_r.out_dir_x <= 16'sd16384 && out_data_r.out_dir_x >= -16'sd16384 &&
      out_data_r.out_dir_y <= 16'sd16384 && out_data_r.out_dir_y >= -16'sd16384 &&
      out_data_r.out_dir_z <= 16'sd16384 && out_data_r.out_dir_z >= -16'sd16384)
    else $error("direction component beyond unit length");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    recip_busy |-> !accept)
    else $error("transfer accepted while the reciprocal is being computed");

endmodule
